// ----- rtl/core/rvc_pkg.sv -----
// rvc_pkg: shared constants and types for the rvc frame parser
// used by every module of the frame parser; no dependencies
`default_nettype none

package rvc_pkg;

    localparam int WIN_LEN     = 19;
    localparam int FILL_W      = $clog2(WIN_LEN + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] SYNC_BYTE = 8'hAA;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 120;

    // declared msb first so the packed value matches the m_tdata layout
    typedef struct packed {
        logic        [7:0]  motion_request;
        logic        [7:0]  motion_intent;
        logic signed [15:0] accel_z;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_x;
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic        [7:0]  frame_index;
    } frame_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/rvc_front.sv -----
// rvc_front: byte window, fill count and running checksum; detects frames
// depends on rvc_pkg
`default_nettype none

module rvc_front (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            byte_valid,
    input  wire logic [7:0]                      byte_data,
    input  wire rvc_pkg::queue_status_t          q_status,
    output logic                                 byte_ready,
    output logic                                 push,
    output rvc_pkg::frame_t                      push_frame
);

    logic [7:0]                 win_reg [rvc_pkg::WIN_LEN];
    logic [rvc_pkg::FILL_W-1:0] fill_reg;
    logic [rvc_pkg::FILL_W-1:0] fill_inc;
    logic [rvc_pkg::FILL_W-1:0] fill_next;
    logic [7:0]                 sum_reg;
    logic [7:0]                 sum_next;
    logic                       accept;
    logic                       hit;

    assign byte_ready = !q_status.full;
    assign accept     = byte_valid && byte_ready;

    // sum of window bytes 2..17 after the shift
    assign sum_next = sum_reg - win_reg[2] + win_reg[rvc_pkg::WIN_LEN-1];

    always_comb begin
        if (fill_reg == rvc_pkg::FILL_W'(rvc_pkg::WIN_LEN)) begin
            fill_inc = fill_reg;
        end else begin
            fill_inc = fill_reg + rvc_pkg::FILL_W'(1);
        end
        hit = (fill_inc == rvc_pkg::FILL_W'(rvc_pkg::WIN_LEN))
              && (win_reg[1] == rvc_pkg::SYNC_BYTE)
              && (win_reg[2] == rvc_pkg::SYNC_BYTE)
              && (sum_next == byte_data);
        fill_next = hit ? '0 : fill_inc;
    end

    // fields taken from the window as it stands after the shift
    always_comb begin
        push_frame.frame_index    = win_reg[3];
        push_frame.yaw            = {win_reg[5],  win_reg[4]};
        push_frame.pitch          = {win_reg[7],  win_reg[6]};
        push_frame.roll           = {win_reg[9],  win_reg[8]};
        push_frame.accel_x        = {win_reg[11], win_reg[10]};
        push_frame.accel_y        = {win_reg[13], win_reg[12]};
        push_frame.accel_z        = {win_reg[15], win_reg[14]};
        push_frame.motion_intent  = win_reg[16];
        push_frame.motion_request = win_reg[17];
    end

    assign push = accept && hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            sum_reg  <= '0;
            for (int i = 0; i < rvc_pkg::WIN_LEN; i++) begin
                win_reg[i] <= '0;
            end
        end else if (accept) begin
            fill_reg <= fill_next;
            sum_reg  <= sum_next;
            for (int i = 0; i < rvc_pkg::WIN_LEN - 1; i++) begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[rvc_pkg::WIN_LEN-1] <= byte_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/rvc_queue.sv -----
// rvc_queue: short frame queue between the front and back parts
// depends on rvc_pkg
`default_nettype none

module rvc_queue (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   push,
    input  wire rvc_pkg::frame_t        push_frame,
    input  wire logic                   pop,
    output rvc_pkg::queue_status_t      status,
    output rvc_pkg::frame_t             head
);

    rvc_pkg::frame_t             mem [rvc_pkg::QUEUE_DEPTH];
    logic [rvc_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [rvc_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [rvc_pkg::QCNT_W-1:0]  count_reg;
    logic [rvc_pkg::QCNT_W-1:0]  count_next;
    logic                        do_push;
    logic                        do_pop;

    assign status.full  = (count_reg == rvc_pkg::QCNT_W'(rvc_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + rvc_pkg::QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - rvc_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_frame;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + rvc_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + rvc_pkg::QPTR_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/rvc_back.sv -----
// rvc_back: output register that presents frames on the result channel
// depends on rvc_pkg
`default_nettype none

module rvc_back (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire rvc_pkg::queue_status_t            q_status,
    input  wire rvc_pkg::frame_t                   head,
    output logic                                   pop,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [rvc_pkg::OUT_DATA_W-1:0]         out_data
);

    logic            valid_reg;
    logic            valid_next;
    rvc_pkg::frame_t data_reg;

    assign pop        = !q_status.empty && (!valid_reg || out_ready);
    assign valid_next = pop || (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign out_data   = data_reg;

    always_ff @(posedge aclk) begin
        if (pop) begin
            data_reg <= head;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/rvc_frame_parser_top.sv -----
// path: a frame enters the frame queue at the edge that takes its last byte, and the
// output register then loads it from the queue head and raises m_tvalid
// throughput: one byte per cycle; the front stalls only when the two-entry
// frame queue is full
// reset: synchronous, active low; clears byte window, fill count, checksum, queue and output valid
// rvc_frame_parser_top: top level joining front, frame queue and back
// depends on rvc_pkg, rvc_front, rvc_queue, rvc_back
`default_nettype none

module rvc_frame_parser_top (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [rvc_pkg::IN_DATA_W-1:0]      s_tdata,   // rx_byte
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // frame_index, yaw, pitch, roll, accel_x, accel_y, accel_z,
    // motion_intent, motion_request
    output logic [rvc_pkg::OUT_DATA_W-1:0]          m_tdata
);

    rvc_pkg::queue_status_t q_status;
    rvc_pkg::frame_t        push_frame;
    rvc_pkg::frame_t        head;
    logic                   push;
    logic                   pop;

    rvc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (s_tvalid),
        .byte_data  (s_tdata),
        .q_status   (q_status),
        .byte_ready (s_tready),
        .push       (push),
        .push_frame (push_frame)
    );

    rvc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_frame (push_frame),
        .pop        (pop),
        .status     (q_status),
        .head       (head)
    );

    rvc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_status  (q_status),
        .head      (head),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

`default_nettype wire

// ----- rtl/core/rvc_checker.sv -----
// rvc_checker: port-level assertions for the rvc frame parser, with bind
// depends on rvc_pkg and rvc_frame_parser_top
`default_nettype none

module rvc_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic [rvc_pkg::IN_DATA_W-1:0]   s_tdata,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [rvc_pkg::OUT_DATA_W-1:0]  m_tdata
);

    // reset empties the output and reopens the input
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("output valid or input stall after reset");

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result transaction changed while stalled");

    // input stalls only when a result is waiting
    a_stall_needs_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    // a fresh result follows an input transaction, through the frame queue and output register
    a_result_from_input: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result appeared without a completing input transaction");

endmodule

bind rvc_frame_parser_top rvc_checker u_rvc_checker (.*);

`default_nettype wire

// ----- bench/testbench.sv -----
// testbench for rvc_frame_parser_top: byte stream in, parsed frames out
// predicts frames from its own sliding window and checks every m_ transaction
// depends on rvc_pkg and rvc_frame_parser_top
`timescale 1ns / 100ps

module testbench;

    import rvc_pkg::*;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    logic [7:0] pending_bytes [$];
    frame_t     frames_due [$];
    logic [7:0] rx_window [WIN_LEN];
    int         rx_fill = 0;
    int         fails = 0;
    int         tick = 0;
    logic       byte_taken = 1'b0;
    logic       calm;

    rvc_frame_parser_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    assign calm = (tick >= 1000) && (tick < 1600);

    // shift one byte into the window and queue a frame when one completes
    task automatic take_byte(input logic [7:0] b);
        logic [7:0] csum;
        frame_t     f;
        if (rx_fill >= WIN_LEN) begin
            for (int i = 0; i < WIN_LEN - 1; i++)
                rx_window[i] = rx_window[i + 1];
            rx_window[WIN_LEN - 1] = b;
        end else begin
            rx_window[rx_fill] = b;
            rx_fill++;
        end
        if (rx_fill == WIN_LEN && rx_window[0] == SYNC_BYTE && rx_window[1] == SYNC_BYTE) begin
            csum = 8'h00;
            for (int i = 2; i < WIN_LEN - 1; i++)
                csum = csum + rx_window[i];
            if (csum == rx_window[WIN_LEN - 1]) begin
                f.frame_index    = rx_window[2];
                f.yaw            = {rx_window[4], rx_window[3]};
                f.pitch          = {rx_window[6], rx_window[5]};
                f.roll           = {rx_window[8], rx_window[7]};
                f.accel_x        = {rx_window[10], rx_window[9]};
                f.accel_y        = {rx_window[12], rx_window[11]};
                f.accel_z        = {rx_window[14], rx_window[13]};
                f.motion_intent  = rx_window[15];
                f.motion_request = rx_window[16];
                frames_due.push_back(f);
                rx_fill = 0;
            end
        end
    endtask

    // skew adds to the checksum byte, lead replaces the first sync byte
    task automatic queue_frame(input frame_t f, input logic [7:0] spare,
                               input logic [7:0] skew, input logic [7:0] lead);
        logic [7:0] body [16];
        logic [7:0] csum;
        body = '{f.frame_index, f.yaw[7:0], f.yaw[15:8], f.pitch[7:0], f.pitch[15:8],
                 f.roll[7:0], f.roll[15:8], f.accel_x[7:0], f.accel_x[15:8],
                 f.accel_y[7:0], f.accel_y[15:8], f.accel_z[7:0], f.accel_z[15:8],
                 f.motion_intent, f.motion_request, spare};
        csum = 8'h00;
        pending_bytes.push_back(lead);
        pending_bytes.push_back(SYNC_BYTE);
        foreach (body[i]) begin
            pending_bytes.push_back(body[i]);
            csum = csum + body[i];
        end
        pending_bytes.push_back(csum + skew);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t %s expected %h actual %h", $time, name, want, got);
            fails++;
        end
    endtask

    always @(negedge aclk) begin
        tick <= tick + 1;
        m_tready <= calm || ($urandom_range(99) >= 13);
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || byte_taken) begin
            if (pending_bytes.size() != 0 && (calm || $urandom_range(99) >= 13)) begin
                s_tdata  <= pending_bytes.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin : monitor
        frame_t got;
        frame_t want;
        byte_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready)
            take_byte(s_tdata);
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (frames_due.size() == 0) begin
                $display("%0t unexpected frame, expected none actual %h", $time, m_tdata);
                fails++;
            end else begin
                want = frames_due.pop_front();
                check_field("frame_index", want.frame_index, got.frame_index);
                check_field("yaw", want.yaw, got.yaw);
                check_field("pitch", want.pitch, got.pitch);
                check_field("roll", want.roll, got.roll);
                check_field("accel_x", want.accel_x, got.accel_x);
                check_field("accel_y", want.accel_y, got.accel_y);
                check_field("accel_z", want.accel_z, got.accel_z);
                check_field("motion_intent", want.motion_intent, got.motion_intent);
                check_field("motion_request", want.motion_request, got.motion_request);
            end
        end
    end

    initial begin
        frame_t         f;
        logic   [127:0] r;
        int             base;
        int             pick;

        // all-zero and all-one payloads
        f = '0;
        queue_frame(f, 8'h00, 8'h00, SYNC_BYTE);
        f = '1;
        queue_frame(f, 8'hFF, 8'h00, SYNC_BYTE);
        // signed extremes
        f = '0;
        f.frame_index    = 8'h80;
        f.yaw            = 16'sh8000;
        f.pitch          = 16'sh7FFF;
        f.roll           = 16'shFFFF;
        f.accel_x        = 16'sh0001;
        f.accel_z        = 16'sh8000;
        f.motion_intent  = 8'h7F;
        f.motion_request = 8'h01;
        queue_frame(f, 8'hAA, 8'h00, SYNC_BYTE);
        // bad checksum, no frame
        queue_frame(f, 8'h55, 8'h01, SYNC_BYTE);
        // misaligned start, frame found only after the window shifts
        pending_bytes.push_back(8'h12);
        pending_bytes.push_back(SYNC_BYTE);
        f.frame_index = 8'h01;
        queue_frame(f, 8'h3C, 8'h00, SYNC_BYTE);

        base = pending_bytes.size();
        while (pending_bytes.size() - base < 1700) begin
            r = {$urandom(), $urandom(), $urandom(), $urandom()};
            f = r[OUT_DATA_W-1:0];
            pick = $urandom_range(99);
            if (pick < 70)
                queue_frame(f, 8'($urandom_range(255)), 8'h00, SYNC_BYTE);
            else if (pick < 80)
                queue_frame(f, 8'($urandom_range(255)), 8'($urandom_range(1, 255)), SYNC_BYTE);
            else if (pick < 88)
                queue_frame(f, 8'($urandom_range(255)), 8'h00,
                            SYNC_BYTE ^ 8'($urandom_range(1, 255)));
            else
                repeat ($urandom_range(1, 20))
                    pending_bytes.push_back(($urandom_range(3) == 0) ? SYNC_BYTE
                                                                      : 8'($urandom_range(255)));
        end

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_bytes.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (frames_due.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (fails == 0)
            $display("rvc_frame_parser_top: match");
        else
            $display("rvc_frame_parser_top: mismatch");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("rvc_frame_parser_top: mismatch");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/rvc_pkg.sv
rtl/core/rvc_front.sv
rtl/core/rvc_queue.sv
rtl/core/rvc_back.sv
rtl/core/rvc_frame_parser_top.sv
rtl/core/rvc_checker.sv
bench/testbench.sv
